FILE: rtl/brfps_pkg.sv
// ----------------------------------------------------------------------------
// brfps_pkg
// Shared types and constants for the byte ring FIFO with pattern search.
// ----------------------------------------------------------------------------
package brfps_pkg;

	// default sizes
	localparam int DEF_CAPACITY    = 256;
	localparam int DEF_MAX_PATTERN = 8;

	// fixed field widths
	localparam int BYTE_W   = 8;
	localparam int FILL_W   = 9;
	localparam int PLEN_W   = 4;
	localparam int PBYTES_W = 64;
	localparam int CFG_IDX_W = 2;

	// commands carried on the input channel
	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_FIND = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_SHORT     = 2'd1,
		STAT_OVERWRITE = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} stat_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd1;

	// control state
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_SCAN = 2'd2,
		ST_HOLD = 2'd3
	} state_t;

	// one result item
	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [BYTE_W-1:0] moff;
		stat_t             status;
		logic [BYTE_W-1:0] data;
	} result_t;

	// control of the match cell row
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

endpackage

FILE: rtl/brfps_cell.sv
// ----------------------------------------------------------------------------
// brfps_cell
// One match cell: holds the flag "pattern bytes 0..k match, ending at the
// last byte seen" and hands it on to the next cell.
// ----------------------------------------------------------------------------
module brfps_cell
	import brfps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [BYTE_W-1:0] pat_byte,
	input  logic              prev_flag,
	output logic              flag
);

	logic flag_q;

	// extend the partial match of the left neighbor by one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.clear) begin
			flag_q <= 1'b0;
		end else if (ctl.shift) begin
			flag_q <= prev_flag && (byte_in == pat_byte);
		end
	end

	assign flag = flag_q;

endmodule

FILE: rtl/brfps_chain.sv
// ----------------------------------------------------------------------------
// brfps_chain
// Row of match cells fed by the scanned byte stream; reports a full match
// of the active pattern length ending at the last byte.
// ----------------------------------------------------------------------------
module brfps_chain
	import brfps_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cell_ctl_t                   ctl,
	input  logic [BYTE_W-1:0]           byte_in,
	input  logic [BYTE_W*MAX_PATTERN-1:0] pattern,
	input  logic [PLEN_W-1:0]           len,
	output logic                        match
);

	logic [MAX_PATTERN-1:0] flags;

	// cell k compares against pattern byte k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic prev;
		if (k == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_rest
			assign prev = flags[k-1];
		end
		brfps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.byte_in   (byte_in),
			.pat_byte  (pattern[BYTE_W*k +: BYTE_W]),
			.prev_flag (prev),
			.flag      (flags[k])
		);
	end

	// pick the flag of the last active cell
	always_comb begin
		match = 1'b0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (len == PLEN_W'(k + 1)) begin
				match = flags[k];
			end
		end
	end

endmodule

FILE: rtl/byte_ring_fifo_with_pattern_search.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_pattern_search
// Circular byte store with push, pop, peek and sync pattern find commands.
// ----------------------------------------------------------------------------
// Usage:
// - input stream: s_tuser carries the command (push, pop, peek, find),
//   s_tdata the push byte and the peek offset; one transfer per command
// - output stream: one result transfer per command with status in m_tuser
//   and read byte, match offset and fill count in m_tdata
// - config channel: cfg_index/cfg_data write pattern length and pattern
//   bytes; always ready, write only while no command is in flight
// - push and immediate errors form their result as the command is taken,
//   pop and peek after one registered read of the store memory; find scans up
//   to min(fill, 255 + length) stored bytes, reading one stored byte per
//   cycle through the memory port into a row of match cells
// - a formed result is registered into the output register once it is free;
//   one further result is held internally while the receiver stalls, and
//   no new command is taken until it moves on
// - reset clears indexes, fill count, pattern bytes and handshakes (length
//   becomes one); the byte store is not cleared and is read only where written
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_pattern_search
	import brfps_pkg::*;
#(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [7:0] data_in, [15:8] peek_offset
	input  logic [1:0]           s_tuser,   // [1:0] command
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [7:0] data_out, [15:8] match_offset,
	                                        // [24:16] fill_count, rest zero
	output logic [1:0]           m_tuser,   // [1:0] status
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PBYTES_W-1:0]  cfg_data
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMPW  = (CNT_W > FILL_W) ? CNT_W : FILL_W;

	// state
	state_t               state_q, state_d;
	logic [AW-1:0]        wr_idx_q, rd_idx_q;
	logic [CNT_W-1:0]     fill_q;
	logic [PLEN_W-1:0]    plen_q;
	logic [PBYTES_W-1:0]  pbytes_q;
	result_t              hold_q, out_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    mem_q [CAPACITY];
	logic [BYTE_W-1:0]    rdata_q;

	// scan pipeline
	logic [CNT_W-1:0]     iss_q, last_q;
	logic                 vld_s1, vld_s2;
	logic [CNT_W-1:0]     off_s1, off_s2;

	// decoded input
	cmd_t                 cmd;
	logic [BYTE_W-1:0]    din, poff;
	logic                 in_xfer, out_free;

	// derived values
	logic                 is_full;
	logic [AW-1:0]        wr_inc, rd_inc, raddr;
	logic [CNT_W-1:0]     push_fill;
	logic [PLEN_W-1:0]    len_eff;
	logic [CMPW-1:0]      scan_lim;
	logic                 issue, match, scan_done, hit_ok;
	logic [CNT_W-1:0]     hit_start;
	cell_ctl_t            cell_ctl;
	logic                 res_valid;
	result_t              res;

	// ring index helpers
	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
		return (idx == AW'(CAPACITY - 1)) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
		input logic [AW-1:0] b);
		logic [AW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (AW+1)'(CAPACITY)) begin
			sum = sum - (AW+1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [FILL_W-1:0] fill_sat(input logic [CNT_W-1:0] f);
		return (CMPW'(f) > CMPW'(511)) ? FILL_W'(511) : FILL_W'(f);
	endfunction

	assign cmd       = cmd_t'(s_tuser);
	assign din       = s_tdata[7:0];
	assign poff      = s_tdata[15:8];
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign is_full   = (fill_q == CNT_W'(CAPACITY));
	assign wr_inc    = ring_inc(wr_idx_q);
	assign rd_inc    = ring_inc(rd_idx_q);
	assign push_fill = is_full ? fill_q : fill_q + CNT_W'(1);

	// effective pattern length, clamped to 1..MAX_PATTERN
	always_comb begin
		if (plen_q == '0) begin
			len_eff = PLEN_W'(1);
		end else if (plen_q > PLEN_W'(MAX_PATTERN)) begin
			len_eff = PLEN_W'(MAX_PATTERN);
		end else begin
			len_eff = plen_q;
		end
	end

	// last scanned offset bound: starts 0..255 only
	always_comb begin
		if (CMPW'(fill_q) < CMPW'(255) + CMPW'(len_eff)) begin
			scan_lim = CMPW'(fill_q);
		end else begin
			scan_lim = CMPW'(255) + CMPW'(len_eff);
		end
	end

	assign issue = (state_q == ST_SCAN) && (iss_q <= last_q);

	// memory read address
	always_comb begin
		raddr = rd_idx_q;
		if (state_q == ST_SCAN) begin
			raddr = ring_add(rd_idx_q, AW'(iss_q));
		end else if (in_xfer && cmd == CMD_PEEK) begin
			raddr = ring_add(rd_idx_q, AW'(poff));
		end
	end

	// byte store, registered read
	always_ff @(posedge clk) begin
		if (in_xfer && cmd == CMD_PUSH) begin
			mem_q[wr_idx_q] <= din;
		end
		rdata_q <= mem_q[raddr];
	end

	// match cell row
	assign cell_ctl.clear = in_xfer && (cmd == CMD_FIND);
	assign cell_ctl.shift = vld_s1;

	brfps_chain #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cell_ctl),
		.byte_in (rdata_q),
		.pattern (pbytes_q[BYTE_W*MAX_PATTERN-1:0]),
		.len     (len_eff),
		.match   (match)
	);

	assign hit_start = off_s2 - CNT_W'(len_eff - PLEN_W'(1));
	assign hit_ok    = match && (CMPW'(hit_start) <= CMPW'(255));
	assign scan_done = vld_s2 && (match || (off_s2 == last_q));

	// result forming
	always_comb begin
		res_valid   = 1'b0;
		res.data    = '0;
		res.status  = STAT_OK;
		res.moff    = '0;
		res.fill    = fill_sat(fill_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (cmd)
						CMD_PUSH: begin
							res_valid  = 1'b1;
							res.status = is_full ? STAT_OVERWRITE : STAT_OK;
							res.fill   = fill_sat(push_fill);
						end
						CMD_POP: begin
							if (fill_q == '0) begin
								res_valid  = 1'b1;
								res.status = STAT_SHORT;
							end
						end
						CMD_PEEK: begin
							if (CMPW'(poff) >= CMPW'(fill_q)) begin
								res_valid  = 1'b1;
								res.status = STAT_SHORT;
							end
						end
						default: begin
							if (CMPW'(fill_q) < CMPW'(len_eff)) begin
								res_valid  = 1'b1;
								res.status = STAT_NOT_FOUND;
							end
						end
					endcase
				end
			end
			ST_READ: begin
				res_valid = 1'b1;
				res.data  = rdata_q;
			end
			ST_SCAN: begin
				if (scan_done) begin
					res_valid = 1'b1;
					if (hit_ok) begin
						res.moff = BYTE_W'(hit_start);
					end else begin
						res.status = STAT_NOT_FOUND;
					end
				end
			end
			ST_HOLD: begin
				res_valid = 1'b1;
				res       = hold_q;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (res_valid) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end else if (state_q == ST_IDLE && in_xfer) begin
			state_d = (cmd == CMD_FIND) ? ST_SCAN : ST_READ;
		end
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = out_valid_q;
		m_tuser  = out_q.status;
		m_tdata  = {7'd0, out_q.fill, out_q.moff, out_q.data};
	end

	// control state, indexes and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				case (cmd)
					CMD_PUSH: begin
						wr_idx_q <= wr_inc;
						fill_q   <= push_fill;
						if (is_full) begin
							rd_idx_q <= wr_inc;
						end
					end
					CMD_POP: begin
						if (fill_q != '0) begin
							rd_idx_q <= rd_inc;
							fill_q   <= fill_q - CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= PLEN_W'(1);
			pbytes_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: plen_q   <= cfg_data[PLEN_W-1:0];
				REG_PATTERN_BYTES:  pbytes_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// scan issue counter and byte pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && cmd == CMD_FIND) begin
			iss_q  <= '0;
			last_q <= CNT_W'(scan_lim - CMPW'(1));
		end else if (issue) begin
			iss_q <= iss_q + CNT_W'(1);
		end
		off_s1 <= iss_q;
		off_s2 <= off_s1;
	end

	// output register and stall hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
		if (res_valid && !out_free) begin
			hold_q <= res;
		end
	end

endmodule

FILE: tb/byte_ring_fifo_with_pattern_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_pattern_search_tb
// Self-checking bench for the byte ring FIFO with sync pattern search. A
// short directed table covers empty and short reads and the reset pattern.
// Random phases follow, one per pattern setting. They mix push bursts,
// planted patterns with partial prefixes, fills past full, drains, peeks,
// finds and noise. Each result is checked against its table row or an in-bench
// model of the ring, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_pattern_search_tb;
	import brfps_pkg::*;

	localparam int RING_DEPTH   = DEF_CAPACITY;
	localparam int RING_AW      = $clog2(RING_DEPTH);
	localparam int SYNC_MAX     = DEF_MAX_PATTERN;
	localparam int DIR_ROWS     = 17;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 145;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_AFTER   = 600;
	localparam int HOLD_CYCLES  = 400;

	// register indexes the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // [7:0] data_in, [15:8] peek_offset
	logic [1:0]           s_tuser;   // [1:0] command
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;   // [7:0] data_out, [15:8] match_offset,
	                                 // [24:16] fill_count, rest zero
	logic [1:0]           m_tuser;   // [1:0] status
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PBYTES_W-1:0]  cfg_data;

	byte_ring_fifo_with_pattern_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// ring model state and pattern registers
	logic [7:0]          ring_mem [RING_DEPTH];
	int unsigned         wr_ptr;
	int unsigned         rd_ptr;
	bit                  ring_full;
	logic [PLEN_W-1:0]   sync_len;
	logic [PBYTES_W-1:0] sync_pat;

	result_t replies_due [$];
	result_t reply_seen;
	int      mismatches;
	int      results_taken;
	int      items_sent;
	int      burst_left;
	int      idle_cycles;

	function automatic int unsigned ring_fill();
		if (ring_full)
			return RING_DEPTH;
		return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
	endfunction

	// effective pattern length: zero acts as one, long values clamp
	function automatic int unsigned sync_span();
		if (sync_len == 0)
			return 1;
		if (sync_len > SYNC_MAX)
			return SYNC_MAX;
		return 32'(sync_len);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// apply one command to the ring model and return its reply
	function automatic result_t ring_step(cmd_t cmd, logic [7:0] din, logic [7:0] poff);
		result_t     r;
		int unsigned used;
		int unsigned span;
		bit          found;
		bit          same;
		r = '0;
		case (cmd)
			CMD_PUSH: begin
				ring_mem[RING_AW'(wr_ptr)] = din;
				wr_ptr = (wr_ptr + 1) % RING_DEPTH;
				if (ring_full) begin
					rd_ptr = wr_ptr;
					r.status = STAT_OVERWRITE;
				end else if (wr_ptr == rd_ptr) begin
					ring_full = 1'b1;
				end
			end
			CMD_POP: begin
				if (ring_fill() == 0) begin
					r.status = STAT_SHORT;
				end else begin
					r.data = ring_mem[RING_AW'(rd_ptr)];
					rd_ptr = (rd_ptr + 1) % RING_DEPTH;
					ring_full = 1'b0;
				end
			end
			CMD_PEEK: begin
				if (poff >= ring_fill())
					r.status = STAT_SHORT;
				else
					r.data = ring_mem[RING_AW'((rd_ptr + poff) % RING_DEPTH)];
			end
			default: begin
				// leftmost full match, starts 0..255 only
				span = sync_span();
				used = ring_fill();
				found = 1'b0;
				for (int s = 0; s + span <= used && s <= 255 && !found; s++) begin
					same = 1'b1;
					for (int k = 0; k < span; k++)
						if (ring_mem[RING_AW'((rd_ptr + s + k) % RING_DEPTH)] !=
								sync_pat[8*k +: 8])
							same = 1'b0;
					if (same) begin
						found = 1'b1;
						r.moff = s[7:0];
					end
				end
				if (!found)
					r.status = STAT_NOT_FOUND;
			end
		endcase
		used = ring_fill();
		r.fill = (used > 511) ? 9'd511 : used[8:0];
		return r;
	endfunction

	// directed table: expected reply is {fill, match_offset, status, data_out}
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] din;
		logic [7:0] poff;
		logic       typed;
		result_t    want;
	} dir_row_t;

	// reset pattern is one zero byte
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_POP,  8'hFF, 8'hFF, 1'b1, '{9'd0, 8'h00, STAT_SHORT,     8'h00}},
		'{CMD_PEEK, 8'hFF, 8'h00, 1'b1, '{9'd0, 8'h00, STAT_SHORT,     8'h00}},
		'{CMD_FIND, 8'h00, 8'hFF, 1'b1, '{9'd0, 8'h00, STAT_NOT_FOUND, 8'h00}},
		'{CMD_PUSH, 8'hFF, 8'hFF, 1'b1, '{9'd1, 8'h00, STAT_OK,        8'h00}},
		'{CMD_PUSH, 8'h00, 8'h00, 1'b1, '{9'd2, 8'h00, STAT_OK,        8'h00}},
		'{CMD_FIND, 8'hFF, 8'hFF, 1'b1, '{9'd2, 8'h01, STAT_OK,        8'h00}},
		'{CMD_PEEK, 8'h00, 8'h00, 1'b1, '{9'd2, 8'h00, STAT_OK,        8'hFF}},
		'{CMD_PEEK, 8'hFF, 8'h01, 1'b1, '{9'd2, 8'h00, STAT_OK,        8'h00}},
		'{CMD_PEEK, 8'h00, 8'h02, 1'b1, '{9'd2, 8'h00, STAT_SHORT,     8'h00}},
		'{CMD_PEEK, 8'h00, 8'hFF, 1'b1, '{9'd2, 8'h00, STAT_SHORT,     8'h00}},
		'{CMD_PUSH, 8'hA5, 8'h5A, 1'b1, '{9'd3, 8'h00, STAT_OK,        8'h00}},
		'{CMD_POP,  8'h00, 8'h00, 1'b1, '{9'd2, 8'h00, STAT_OK,        8'hFF}},
		'{CMD_POP,  8'hFF, 8'hFF, 1'b1, '{9'd1, 8'h00, STAT_OK,        8'h00}},
		'{CMD_FIND, 8'h00, 8'h00, 1'b1, '{9'd1, 8'h00, STAT_NOT_FOUND, 8'h00}},
		'{CMD_PEEK, 8'h5A, 8'h00, 1'b0, '0},
		'{CMD_POP,  8'h00, 8'h00, 1'b1, '{9'd0, 8'h00, STAT_OK,        8'hA5}},
		'{CMD_POP,  8'hFF, 8'hFF, 1'b1, '{9'd0, 8'h00, STAT_SHORT,     8'h00}}
	};

	// one command transfer; called right after a falling edge
	task automatic send_item(input cmd_t cmd, input logic [7:0] din, input logic [7:0] poff,
			input bit typed = 1'b0, input result_t typed_want = '0);
		int      gap;
		result_t pred;
		if (burst_left == 0) begin
			case ($urandom_range(0, 5))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 5);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {poff, din};
		do @(posedge clk); while (!s_tready);
		pred = ring_step(cmd, din, poff);
		replies_due.push_back(typed ? typed_want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// register write; valid is left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PBYTES_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PATTERN_LENGTH)
			sync_len = val[PLEN_W-1:0];
		else if (idx == REG_PATTERN_BYTES)
			sync_pat = val;
		@(negedge clk);
	endtask

	// reconfigure the pattern once every reply is back
	task automatic set_pattern(input logic [PLEN_W-1:0] len_val, input logic [PBYTES_W-1:0] pat,
			input bit spare_writes);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
		write_reg(REG_PATTERN_LENGTH,
				{$urandom, 15'($urandom_range(0, 15'h7FFF)), 13'd0, len_val});
		write_reg(REG_PATTERN_BYTES, pat);
		if (spare_writes) begin
			write_reg(REG_SPARE_A, {$urandom, $urandom});
			write_reg(REG_SPARE_B, {$urandom, $urandom});
		end
		cfg_valid <= 1'b0;
	endtask

	// stored bytes lean on the pattern alphabet so partial matches are common
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return sync_pat[8*$urandom_range(0, sync_span() - 1) +: 8];
			5:             return 8'h00;
			6:             return 8'hFF;
			default:       return rand_byte();
		endcase
	endfunction

	// either fully random, or built from two symbols for self-overlap
	function automatic logic [PBYTES_W-1:0] make_pattern();
		logic [PBYTES_W-1:0] pat;
		logic [7:0]          sym_a;
		logic [7:0]          sym_b;
		sym_a = rand_byte();
		sym_b = rand_byte();
		if ($urandom_range(0, 2) == 0)
			return {$urandom, $urandom};
		for (int k = 0; k < SYNC_MAX; k++)
			pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
		return pat;
	endfunction

	// one phase of random command sequences
	task automatic run_phase(input int n_items);
		int          phase_end;
		int          n;
		int unsigned used;
		phase_end = items_sent + n_items;
		while (items_sent < phase_end) begin
			used = ring_fill();
			case ($urandom_range(0, 99)) inside
				[0:27]: begin
					n = $urandom_range(1, 24);
					repeat (n) send_item(CMD_PUSH, pick_byte(), rand_byte());
				end
				[28:37]: begin
					// planted pattern, sometimes after a partial prefix
					n = $urandom_range(0, sync_span() - 1);
					for (int k = 0; k < n; k++)
						send_item(CMD_PUSH, sync_pat[8*k +: 8], rand_byte());
					for (int k = 0; k < sync_span(); k++)
						send_item(CMD_PUSH, sync_pat[8*k +: 8], rand_byte());
				end
				[38:51]: begin
					n = $urandom_range(1, 12);
					repeat (n) send_item(CMD_POP, rand_byte(), rand_byte());
				end
				[52:63]: begin
					if (used > 0 && $urandom_range(0, 4) != 0)
						send_item(CMD_PEEK, rand_byte(), 8'($urandom_range(0, used - 1)));
					else
						send_item(CMD_PEEK, rand_byte(), rand_byte());
				end
				[64:83]: send_item(CMD_FIND, rand_byte(), rand_byte());
				[84:86]: begin
					// fill up and run past full
					n = RING_DEPTH - used + $urandom_range(1, 8);
					repeat (n) send_item(CMD_PUSH, pick_byte(), rand_byte());
					send_item(CMD_FIND, rand_byte(), rand_byte());
				end
				[87:91]: begin
					// drain past empty
					n = used + $urandom_range(1, 3);
					repeat (n) send_item(CMD_POP, rand_byte(), rand_byte());
				end
				default: send_item(cmd_t'($urandom_range(0, 3)), rand_byte(), rand_byte());
			endcase
		end
	endtask

	// stimulus
	initial begin
		int unsigned         plen_list [PHASES];
		logic [PBYTES_W-1:0] pat;
		plen_list = '{1, 8, 0, 15, 3, 5, 2, 9, 4, 7};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_PUSH;
		cfg_valid = 1'b0;
		cfg_index = REG_PATTERN_LENGTH;
		cfg_data  = '0;
		wr_ptr    = 0;
		rd_ptr    = 0;
		ring_full = 1'b0;
		sync_len  = 4'd1;
		sync_pat  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].cmd, dir_rows[i].din, dir_rows[i].poff,
					dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				pat = '0;
			else if (p == 1)
				pat = '1;
			else
				pat = make_pattern();
			set_pattern(PLEN_W'(plen_list[p]), pat, p % 3 == 1);
			run_phase(PHASE_ITEMS);
		end
		s_tvalid <= 1'b0;

		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("byte_ring_fifo_with_pattern_search: match");
		else
			$display("byte_ring_fifo_with_pattern_search: mismatch");
		$finish;
	end

	// result receiver: switches among stall patterns, one long hold-off
	initial begin
		int  mode;
		int  mode_left;
		int  tick;
		bit  held_off;
		m_tready  = 1'b0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		held_off  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && results_taken >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 4);
				mode_left = $urandom_range(32, 200);
			end
			mode_left--;
			tick++;
			case (mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				3:       m_tready <= (tick % 3 == 0);
				default: m_tready <= (tick % 8 < 5);
			endcase
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// reply check against the oldest outstanding expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_taken++;
			if (replies_due.size() == 0) begin
				$display("%0t: reply with none outstanding, expected none actual tdata %h tuser %h",
						$time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				reply_seen = replies_due.pop_front();
				check_field("data_out", 32'(reply_seen.data), 32'(m_tdata[7:0]));
				check_field("match_offset", 32'(reply_seen.moff), 32'(m_tdata[15:8]));
				check_field("fill_count", 32'(reply_seen.fill), 32'(m_tdata[24:16]));
				check_field("tdata pad", 0, 32'(m_tdata[31:25]));
				check_field("status", 32'(reply_seen.status), 32'(m_tuser));
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("byte_ring_fifo_with_pattern_search: mismatch");
			$finish;
		end
	end

endmodule

FILE: files.f
rtl/brfps_pkg.sv
rtl/brfps_cell.sv
rtl/brfps_chain.sv
rtl/byte_ring_fifo_with_pattern_search.sv
tb/byte_ring_fifo_with_pattern_search_tb.sv
